### hdl/fir_same_size_edge_padded_core_defines.svh
// ----------------------------------------------------------------------------
// fir_same_size_edge_padded_core_defines
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef FIR_SAME_SIZE_EDGE_PADDED_CORE_DEFINES_SVH
`define FIR_SAME_SIZE_EDGE_PADDED_CORE_DEFINES_SVH

// same-cycle implication
`define FSEP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fsep check failed");

// next-cycle implication
`define FSEP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fsep check failed");

`endif

### hdl/fsep_pkg.sv
// ----------------------------------------------------------------------------
// fsep_pkg
// widths, register indexes and reset constants of the same-size fir filter
// ----------------------------------------------------------------------------
package fsep_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int TAP_W      = 16;
    localparam int PROD_W     = 32;
    localparam int OUT_W      = 34;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 40;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [TAP_W-1:0]    tap_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [OUT_W-1:0]    acc_t;
    typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

    // register indexes
    localparam cfg_idx_t REG_PAD_MODE  = 3'd0;
    localparam cfg_idx_t REG_TAP_FIRST = 3'd1;

    // pad mode codes
    localparam logic PAD_ZERO      = 1'b1;
    localparam logic PAD_MODE_RESET = PAD_ZERO;

    // reset kernel is a single centre weight
    localparam int   CENTER_TAP       = 3;
    localparam tap_t CENTER_TAP_RESET = 16'sd32767;

endpackage

### hdl/fir_same_size_edge_padded_core.sv
// ----------------------------------------------------------------------------
// fir_same_size_edge_padded_core
// streaming same-size fir filter with zero or edge-replicate padding
// ----------------------------------------------------------------------------
// Takes one sample per cycle and returns one result per sample, the whole
// vector the same length as the input. Results lag the input vector by
// TAP_COUNT-1-TAP_COUNT/2 samples, and the pipeline has window, product,
// partial sum and output registers. After the last sample of a vector of n
// samples the window shifts in min(n, lag+1)-1 more pad samples, one result
// each, with s_tready low; otherwise s_tready only drops when every pipeline
// register is full and stalled. Configuration writes must be made only while
// the block is idle; the block itself does not enforce this.

module fir_same_size_edge_padded_core #(
    parameter int TAP_COUNT = 7
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_we,
    input  logic [fsep_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fsep_pkg::CFG_DATA_W-1:0]     cfg_data,
    // sample requests
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [fsep_pkg::S_TDATA_W-1:0]      s_tdata,   // [15:0] sample
    input  logic                                s_tlast,   // sample_last
    // result requests
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [fsep_pkg::M_TDATA_W-1:0]      m_tdata,   // [33:0] filtered, zero fill
    output logic                                m_tlast    // filtered_last
);

    localparam int SHIFT  = TAP_COUNT / 2;
    localparam int LAG    = TAP_COUNT - 1 - SHIFT;
    localparam int SEEN_W = (LAG > 0) ? $clog2(LAG + 1) : 1;
    localparam int HALF   = (TAP_COUNT + 1) / 2;

    // configuration
    logic                pad_mode_reg;
    fsep_pkg::tap_t      tap_reg [TAP_COUNT];
    fsep_pkg::cfg_idx_t  tap_sel;

    // window stage
    fsep_pkg::sample_t   win_reg  [TAP_COUNT];
    fsep_pkg::sample_t   win_next [TAP_COUNT];
    logic [SEEN_W-1:0]   seen_reg, seen_next;
    logic [SEEN_W-1:0]   flush_reg, flush_next;
    fsep_pkg::sample_t   rpad_reg, rpad_next;
    logic                a_valid_reg, a_last_reg;
    logic                emit_next, emit_last_next;

    // product stage
    fsep_pkg::prod_t     prod_reg [TAP_COUNT];
    logic                b_valid_reg, b_last_reg;

    // partial sum stage
    fsep_pkg::acc_t      lo_reg, hi_reg;
    fsep_pkg::acc_t      lo_next, hi_next;
    logic                c_valid_reg, c_last_reg;

    // output stage
    fsep_pkg::acc_t      out_reg;
    logic                out_valid_reg, out_last_reg;

    logic                out_adv, c_adv, b_adv, a_adv;
    logic                accept, step;

    // ------------------------------------------------------------------------
    // configuration port

    assign tap_sel = cfg_index - fsep_pkg::REG_TAP_FIRST;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_mode_reg <= fsep_pkg::PAD_MODE_RESET;
            for (int k = 0; k < TAP_COUNT; k++)
            begin
                tap_reg[k] <= (k == fsep_pkg::CENTER_TAP) ? fsep_pkg::CENTER_TAP_RESET
                                                          : '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == fsep_pkg::REG_PAD_MODE)
            begin
                pad_mode_reg <= cfg_data[0];
            end
            else
            begin
                for (int k = 0; k < TAP_COUNT; k++)
                begin
                    if (tap_sel == fsep_pkg::CFG_IDX_W'(k))
                    begin
                        tap_reg[k] <= cfg_data;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // handshake and stage enables

    assign out_adv  = !out_valid_reg || m_tready;
    assign c_adv    = !c_valid_reg || out_adv;
    assign b_adv    = !b_valid_reg || c_adv;
    assign a_adv    = !a_valid_reg || b_adv;
    assign s_tready = a_adv && (flush_reg == '0);
    assign accept   = s_tvalid && s_tready;
    assign step     = a_adv && (flush_reg != '0);

    // ------------------------------------------------------------------------
    // window update

    always_comb
    begin
        fsep_pkg::sample_t            sample;
        fsep_pkg::sample_t            fill;
        fsep_pkg::sample_t            rpad_in;
        fsep_pkg::sample_t            work [TAP_COUNT];
        logic [SEEN_W-1:0]            extra;

        sample  = s_tdata[fsep_pkg::SAMPLE_W-1:0];
        fill    = (pad_mode_reg == fsep_pkg::PAD_ZERO) ? '0 : sample;
        rpad_in = fill;
        extra   = SEEN_W'(LAG) - seen_reg;

        win_next       = win_reg;
        seen_next      = seen_reg;
        flush_next     = flush_reg;
        rpad_next      = rpad_reg;
        emit_next      = 1'b0;
        emit_last_next = 1'b0;

        // first sample of a vector fills the window with the left pad
        for (int k = 0; k < TAP_COUNT; k++)
        begin
            work[k] = (seen_reg == '0) ? fill : win_reg[k];
        end
        for (int k = 0; k < TAP_COUNT - 1; k++)
        begin
            work[k] = work[k + 1];
        end
        work[TAP_COUNT-1] = sample;

        if (accept)
        begin
            if (!s_tlast)
            begin
                win_next = work;
                if (seen_reg >= SEEN_W'(LAG))
                begin
                    emit_next = 1'b1;
                    seen_next = SEEN_W'(LAG);
                end
                else
                begin
                    seen_next = seen_reg + SEEN_W'(1);
                end
            end
            else
            begin
                // last sample: a short vector shifts in right pads up to the centre
                for (int j = 0; j < LAG; j++)
                begin
                    if (SEEN_W'(j) < extra)
                    begin
                        for (int k = 0; k < TAP_COUNT - 1; k++)
                        begin
                            work[k] = work[k + 1];
                        end
                        work[TAP_COUNT-1] = rpad_in;
                    end
                end
                win_next       = work;
                emit_next      = 1'b1;
                emit_last_next = (seen_reg == '0);
                flush_next     = seen_reg;
                seen_next      = '0;
                rpad_next      = rpad_in;
            end
        end
        else if (step)
        begin
            for (int k = 0; k < TAP_COUNT - 1; k++)
            begin
                win_next[k] = win_reg[k + 1];
            end
            win_next[TAP_COUNT-1] = rpad_reg;
            emit_next      = 1'b1;
            emit_last_next = (flush_reg == SEEN_W'(1));
            flush_next     = flush_reg - SEEN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg    <= '0;
            flush_reg   <= '0;
            a_valid_reg <= 1'b0;
            a_last_reg  <= 1'b0;
        end
        else
        begin
            seen_reg  <= seen_next;
            flush_reg <= flush_next;
            if (a_adv)
            begin
                a_valid_reg <= emit_next;
                a_last_reg  <= emit_last_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept || step)
        begin
            win_reg  <= win_next;
            rpad_reg <= rpad_next;
        end
    end

    // ------------------------------------------------------------------------
    // products

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            b_last_reg  <= 1'b0;
        end
        else if (b_adv)
        begin
            b_valid_reg <= a_valid_reg;
            b_last_reg  <= a_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_adv)
        begin
            for (int k = 0; k < TAP_COUNT; k++)
            begin
                prod_reg[k] <= fsep_pkg::PROD_W'(win_reg[k]) * fsep_pkg::PROD_W'(tap_reg[k]);
            end
        end
    end

    // ------------------------------------------------------------------------
    // partial sums

    always_comb
    begin
        lo_next = '0;
        hi_next = '0;
        for (int k = 0; k < TAP_COUNT; k++)
        begin
            if (k < HALF)
            begin
                lo_next = lo_next + fsep_pkg::OUT_W'(prod_reg[k]);
            end
            else
            begin
                hi_next = hi_next + fsep_pkg::OUT_W'(prod_reg[k]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            c_last_reg  <= 1'b0;
        end
        else if (c_adv)
        begin
            c_valid_reg <= b_valid_reg;
            c_last_reg  <= b_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_adv)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    // ------------------------------------------------------------------------
    // output register

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= c_valid_reg;
            out_last_reg  <= c_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv)
        begin
            out_reg <= lo_reg + hi_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(fsep_pkg::M_TDATA_W - fsep_pkg::OUT_W){1'b0}}, out_reg};

endmodule

### hdl/fsep_checker.sv
// ----------------------------------------------------------------------------
// fsep_checker
// port-level checks of the same-size fir filter
// ----------------------------------------------------------------------------
`include "fir_same_size_edge_padded_core_defines.svh"

module fsep_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             cfg_we,
    input logic [fsep_pkg::CFG_IDX_W-1:0]   cfg_index,
    input logic [fsep_pkg::CFG_DATA_W-1:0]  cfg_data,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [fsep_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic                             m_tlast
);

    logic       in_acc, out_acc;
    logic [7:0] pending_reg, pending_next;
    logic       cfg_seen;

    assign in_acc   = s_tvalid && s_tready;
    assign out_acc  = m_tvalid && m_tready;
    assign cfg_seen = cfg_we && (cfg_index == fsep_pkg::REG_PAD_MODE) && cfg_data[0];

    // samples taken whose results are not yet delivered
    always_comb
    begin
        pending_next = pending_reg + 8'(in_acc) - 8'(out_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `FSEP_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    `FSEP_ASSERT_NOW(a_no_extra_result, clk, rst_n, out_acc, pending_reg != 8'd0)
    `FSEP_ASSERT_NOW(a_vector_closed, clk, rst_n, out_acc && pending_reg == 8'd1, m_tlast)
    `FSEP_ASSERT_NOW(a_cfg_idle, clk, rst_n, cfg_seen, !out_acc || pending_reg != 8'd0)

endmodule

bind fir_same_size_edge_padded_core fsep_checker u_fsep_checker (.*);
